### design/pwsg_pkg.sv
// Shared types, register codes and cosine table builder for the waveform generator.
`timescale 1ns / 1ps
package pwsg_pkg;

  typedef enum logic [1:0] {
    REG_PERIOD = 2'd0,
    REG_VOLUME = 2'd1,
    REG_WAVE   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_SAW      = 2'd2,
    WAVE_SQUARE   = 2'd3
  } wave_t;

  typedef struct packed {
    logic        oor;
    logic [15:0] sq;
  } side_t;

  localparam int unsigned        TAYLOR_TERMS = 12;
  localparam longint unsigned    PI_HALF_Q30  = 64'd1686629713;
  localparam longint unsigned    ONE_Q30      = 64'd1 << 30;
  localparam longint unsigned    TAYLOR_DIV [TAYLOR_TERMS] =
    '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
      64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

  function automatic logic [16:0] cos_q16(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned rnd;
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    sum  = longint'(ONE_Q30);
    for (int n = 0; n < TAYLOR_TERMS; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if ((n % 2) == 1) begin
        sum = sum + longint'(term);
      end else begin
        sum = sum - longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    rnd = (longint'(unsigned'(sum)) + 64'd8192) >> 14;
    return rnd[16:0];
  endfunction

endpackage

### design/periodic_waveform_sample_generator.sv
// Top level of the periodic waveform sample generator.
`timescale 1ns / 1ps
// Usage:
//   in_tdata[15:0] carries a sample index; out_tdata[15:0] returns the wave
//   sample and out_tuser flags an index not below the period length (sample 0).
//   Period length, volume and wave type are written through cfg_we/cfg_addr/
//   cfg_wdata while no item is in flight.
// Pipeline: one divider cell per quotient bit (QB the larger of PHASE_BITS
//   and 16) plus input, multiply, table index, table read, complement and
//   output stages. Throughput: one item per cycle while the output is not stalled.
// Stall: the whole pipeline holds while out_tvalid is high and out_tready low;
//   in_tready follows, so no item is lost or repeated.
// Reset: clears all valid flags, period length to 256, volume 0, sine wave.
module periodic_waveform_sample_generator #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int PHASE_BITS       = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample_value
  output logic        out_tuser,  // [0] index_out_of_range
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int QB  = (PHASE_BITS > 16) ? PHASE_BITS : 16;
  localparam int RW  = PHASE_BITS - 2;
  localparam int IW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int KW  = RW + IW + 1;

  logic [15:0] len_r, vol_r;
  logic [1:0]  wave_r;
  logic        adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= 16'd256;
      vol_r  <= 16'd0;
      wave_r <= pwsg_pkg::WAVE_SINE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pwsg_pkg::REG_PERIOD: len_r  <= cfg_wdata;
        pwsg_pkg::REG_VOLUME: vol_r  <= cfg_wdata;
        pwsg_pkg::REG_WAVE:   wave_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // input stage
  logic            v0_r;
  logic [15:0]     idx0_r, m0_r;
  pwsg_pkg::side_t side0_nxt, side0_r;
  logic [16:0]     twice;
  logic [15:0]     m0_nxt;

  always_comb begin
    twice         = {in_tdata, 1'b0};
    side0_nxt.oor = in_tdata >= len_r;
    if (twice < {1'b0, len_r}) begin
      side0_nxt.sq = 16'd0;
      m0_nxt       = in_tdata;
    end else if (twice == {1'b0, len_r}) begin
      side0_nxt.sq = {1'b0, vol_r[15:1]};
      m0_nxt       = len_r - in_tdata;
    end else begin
      side0_nxt.sq = vol_r;
      m0_nxt       = len_r - in_tdata;
    end
    if (wave_r == pwsg_pkg::WAVE_SAW) begin
      m0_nxt = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid;
    end
    if (adv) begin
      idx0_r  <= in_tdata;
      m0_r    <= m0_nxt;
      side0_r <= side0_nxt;
    end
  end

  // multiply stage
  logic            v1_r;
  logic [15:0]     idx1_r;
  logic [31:0]     prod1_r;
  pwsg_pkg::side_t side1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
    if (adv) begin
      idx1_r  <= idx0_r;
      prod1_r <= m0_r * vol_r;
      side1_r <= side0_r;
    end
  end

  // divider chain
  logic [32:0]     wave_num;
  logic [15:0]     hi_c;
  logic [QB-1:0]   lo_c;

  always_comb begin
    wave_num = (wave_r == pwsg_pkg::WAVE_TRIANGLE) ? {prod1_r, 1'b0} : {1'b0, prod1_r};
    if (wave_r == pwsg_pkg::WAVE_SINE) begin
      hi_c = idx1_r;
      lo_c = '0;
    end else begin
      hi_c = wave_num[31:16];
      lo_c = {wave_num[15:0], {(QB-16){1'b0}}};
    end
  end

  logic            cv   [QB+1];
  logic [15:0]     crem [QB+1];
  logic [QB-1:0]   cnum [QB+1];
  logic [QB-1:0]   cquo [QB+1];
  pwsg_pkg::side_t cside[QB+1];

  assign cv[0]    = v1_r;
  assign crem[0]  = hi_c;
  assign cnum[0]  = lo_c;
  assign cquo[0]  = '0;
  assign cside[0] = side1_r;

  for (genvar s = 0; s < QB; s++) begin : g_cell
    pwsg_div_cell #(.QB(QB)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .divisor (len_r),
      .valid_i (cv[s]),
      .rem_i   (crem[s]),
      .num_i   (cnum[s]),
      .quo_i   (cquo[s]),
      .side_i  (cside[s]),
      .valid_o (cv[s+1]),
      .rem_o   (crem[s+1]),
      .num_o   (cnum[s+1]),
      .quo_o   (cquo[s+1]),
      .side_o  (cside[s+1])
    );
  end

  // table index stage
  logic [PHASE_BITS-1:0] phase;
  logic [1:0]            quad;
  logic [RW-1:0]         rest;
  logic [KW-1:0]         kfull;
  logic [IW-1:0]         kc, tidx;
  logic                  va_r, nega_r;
  logic [IW-1:0]         tidx_r;
  logic [15:0]           wqa_r;
  pwsg_pkg::side_t       sidea_r;

  always_comb begin
    phase = cquo[QB][QB-1 -: PHASE_BITS];
    quad  = phase[PHASE_BITS-1 -: 2];
    rest  = phase[RW-1:0];
    kfull = (KW'(rest) * KW'(SINE_TABLE_DEPTH)) >> RW;
    kc    = (kfull > KW'(SINE_TABLE_DEPTH)) ? IW'(SINE_TABLE_DEPTH) : kfull[IW-1:0];
    tidx  = quad[0] ? (IW'(SINE_TABLE_DEPTH) - kc) : kc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= cv[QB];
    end
    if (adv) begin
      tidx_r  <= tidx;
      nega_r  <= quad[0] ^ quad[1];
      wqa_r   <= cquo[QB][QB-1 -: 16];
      sidea_r <= cside[QB];
    end
  end

  // cosine table read
  logic [16:0]     cos_rom [SINE_TABLE_DEPTH+1];
  for (genvar j = 0; j <= SINE_TABLE_DEPTH; j++) begin : g_rom
    assign cos_rom[j] = pwsg_pkg::cos_q16(
      (pwsg_pkg::PI_HALF_Q30 * 64'(j)) / SINE_TABLE_DEPTH);
  end

  logic            vb_r, negb_r;
  logic [16:0]     cb_r;
  logic [15:0]     wqb_r;
  pwsg_pkg::side_t sideb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
    if (adv) begin
      cb_r    <= cos_rom[tidx_r];
      negb_r  <= nega_r;
      wqb_r   <= wqa_r;
      sideb_r <= sidea_r;
    end
  end

  // complement stage
  logic            vc_r;
  logic [17:0]     diffc_r, diffc_nxt;
  logic [15:0]     wqc_r;
  pwsg_pkg::side_t sidec_r;

  assign diffc_nxt = negb_r ? (18'd65536 + {1'b0, cb_r}) : (18'd65536 - {1'b0, cb_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (adv) begin
      vc_r <= vb_r;
    end
    if (adv) begin
      diffc_r <= diffc_nxt;
      wqc_r   <= wqb_r;
      sidec_r <= sideb_r;
    end
  end

  // scale and select into the output register
  logic [33:0] sprod;
  logic [15:0] val_nxt;
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic        out_oor_r;

  always_comb begin
    sprod = diffc_r * vol_r;
    case (wave_r)
      pwsg_pkg::WAVE_SINE:   val_nxt = sprod[32:17];
      pwsg_pkg::WAVE_SQUARE: val_nxt = sidec_r.sq;
      default:               val_nxt = wqc_r;
    endcase
    if (sidec_r.oor) begin
      val_nxt = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vc_r;
    end
    if (adv) begin
      out_data_r <= val_nxt;
      out_oor_r  <= sidec_r.oor;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_oor_r;

`ifndef ASSERT_OFF
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 16'd0)
    else $error("out of range item with nonzero sample");

  a_mute_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && vol_r == 16'd0 |-> out_tdata == 16'd0)
    else $error("nonzero sample at zero volume");

  a_oor_len0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && len_r == 16'd0 |-> out_tuser)
    else $error("zero period item not flagged");
`endif

endmodule

### design/pwsg_div_cell.sv
// One restoring division step: develops one quotient bit and hands the rest on.
`timescale 1ns / 1ps
module pwsg_div_cell #(
  parameter int QB = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [15:0]       divisor,
  input  logic              valid_i,
  input  logic [15:0]       rem_i,
  input  logic [QB-1:0]     num_i,
  input  logic [QB-1:0]     quo_i,
  input  pwsg_pkg::side_t   side_i,
  output logic              valid_o,
  output logic [15:0]       rem_o,
  output logic [QB-1:0]     num_o,
  output logic [QB-1:0]     quo_o,
  output pwsg_pkg::side_t   side_o
);

  logic [16:0]     trial;
  logic            ge;
  logic [16:0]     diff;
  logic            valid_r;
  logic [15:0]     rem_r, rem_nxt;
  logic [QB-1:0]   num_r, num_nxt;
  logic [QB-1:0]   quo_r, quo_nxt;
  pwsg_pkg::side_t side_r;

  always_comb begin
    trial   = {rem_i, num_i[QB-1]};
    ge      = trial >= {1'b0, divisor};
    diff    = trial - {1'b0, divisor};
    rem_nxt = ge ? diff[15:0] : trial[15:0];
    num_nxt = {num_i[QB-2:0], 1'b0};
    quo_nxt = {quo_i[QB-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
    if (en) begin
      rem_r  <= rem_nxt;
      num_r  <= num_nxt;
      quo_r  <= quo_nxt;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign num_o   = num_r;
  assign quo_o   = quo_r;
  assign side_o  = side_r;

endmodule

### tb/sv/periodic_waveform_sample_generator_test.sv
// Self-checking testbench: random and directed sample indices against a waveform predictor.
`timescale 1ns / 1ps
module periodic_waveform_sample_generator_test;

  localparam int TBL_DEPTH = 256;
  localparam int PH_BITS   = 16;
  localparam int LATENCY   = PH_BITS + 6;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic        oor;
    logic [15:0] val;
  } wave_sample_t;

  class wave_scoreboard;
    logic [15:0] period_len;
    logic [15:0] vol;
    pwsg_pkg::wave_t shape;
    longint      cos_tbl [TBL_DEPTH + 1];
    wave_sample_t pending [$];
    int          errors;

    function new();
      longint unsigned x, x2, term;
      longint acc;
      period_len = 16'd256;
      vol = 16'd0;
      shape = pwsg_pkg::WAVE_SINE;
      errors = 0;
      for (int j = 0; j <= TBL_DEPTH; j++) begin
        x = (HALF_PI_Q30 * longint'(j)) / TBL_DEPTH;
        x2 = (x * x) >> 30;
        term = 64'd1 << 30;
        acc = longint'(64'd1 << 30);
        for (int n = 0; n < 12; n++) begin
          term = ((term * x2) >> 30) / longint'((2 * n + 1) * (2 * n + 2));
          if (n % 2 == 1) acc = acc + longint'(term);
          else acc = acc - longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > longint'(64'd1 << 30)) acc = longint'(64'd1 << 30);
        cos_tbl[j] = (acc + 8192) >>> 14;
      end
    endfunction

    function void write_reg(pwsg_pkg::reg_idx_t idx, logic [15:0] value);
      case (idx)
        pwsg_pkg::REG_PERIOD: period_len = value;
        pwsg_pkg::REG_VOLUME: vol = value;
        pwsg_pkg::REG_WAVE:   shape = pwsg_pkg::wave_t'(value[1:0]);
        default: ;
      endcase
    endfunction

    function wave_sample_t compute_sample(logic [15:0] idx);
      longint unsigned i, len, v, ph, quad, rest, k, s;
      longint c;
      wave_sample_t r;
      i = idx;
      len = period_len;
      v = vol;
      r.oor = 1'b0;
      if (i >= len) begin
        r.oor = 1'b1;
        r.val = 16'd0;
        return r;
      end
      case (shape)
        pwsg_pkg::WAVE_SINE: begin
          ph = (i << PH_BITS) / len;
          quad = (ph >> (PH_BITS - 2)) & 3;
          rest = ph & ((64'd1 << (PH_BITS - 2)) - 1);
          k = (rest * TBL_DEPTH) >> (PH_BITS - 2);
          if (k > TBL_DEPTH) k = TBL_DEPTH;
          case (quad)
            0: c = cos_tbl[k];
            1: c = -cos_tbl[TBL_DEPTH - k];
            2: c = -cos_tbl[k];
            default: c = cos_tbl[TBL_DEPTH - k];
          endcase
          s = (longint'(65536 - c) * v) >> 17;
        end
        pwsg_pkg::WAVE_TRIANGLE:
          s = (2 * i < len) ? (2 * i * v) / len : (2 * (len - i) * v) / len;
        pwsg_pkg::WAVE_SAW: s = (i * v) / len;
        default: s = (2 * i < len) ? 0 : ((2 * i == len) ? (v >> 1) : v);
      endcase
      r.val = s[15:0];
      return r;
    endfunction

    function void note_index(logic [15:0] idx);
      pending.push_back(compute_sample(idx));
    endfunction

    function void check_sample(logic [15:0] val, logic oor);
      wave_sample_t e;
      if (pending.size() == 0) begin
        $error("unexpected sample: sample_value %0d index_out_of_range %0d", val, oor);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.val !== val) begin
        $error("sample_value: expected %0d, actual %0d", e.val, val);
        errors++;
      end
      if (e.oor !== oor) begin
        $error("index_out_of_range: expected %0d, actual %0d", e.oor, oor);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  wave_scoreboard sb = new();
  bit  idle_free = 1'b0;
  longint cycles = 0;

  periodic_waveform_sample_generator dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_sample(out_tdata, out_tuser);
  end

  always @(negedge clk) begin
    out_tready <= idle_free ? 1'b1 : ($urandom_range(99) >= 18);
  end

  task automatic write_reg(pwsg_pkg::reg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_index(logic [15:0] idx);
    while (!idle_free && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= idx;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_index(idx);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic random_phase(int n, logic [15:0] len);
    logic [15:0] idx;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) idx = 16'($urandom_range(65535));
      else if (len == 0) idx = 16'($urandom_range(3));
      else idx = 16'($urandom_range(len - 1));
      if ($urandom_range(15) == 0 && len != 0) idx = len;
      send_index(idx);
    end
  endtask

  initial begin
    logic [15:0] len;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    // Reset settings: sine with zero volume
    send_index(16'd0);
    send_index(16'd255);
    send_index(16'd256);
    drain();
    write_reg(pwsg_pkg::REG_VOLUME, 16'hFFFF);
    write_reg(pwsg_pkg::REG_PERIOD, 16'd256);
    for (int w = 0; w < 4; w++) begin
      write_reg(pwsg_pkg::REG_WAVE, 16'(w));
      send_index(16'd0);
      send_index(16'd64);
      send_index(16'd128);
      send_index(16'd192);
      send_index(16'd255);
      drain();
    end
    write_reg(pwsg_pkg::REG_PERIOD, 16'd0);
    send_index(16'd0);
    send_index(16'hFFFF);
    drain();
    write_reg(pwsg_pkg::REG_PERIOD, 16'hFFFF);
    write_reg(pwsg_pkg::REG_WAVE, 16'(pwsg_pkg::WAVE_SAW));
    send_index(16'hFFFE);
    send_index(16'hFFFF);
    drain();
    write_reg(pwsg_pkg::REG_PERIOD, 16'd1);
    send_index(16'd0);
    drain();
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: len = 16'd1;
        1: len = 16'd2;
        2: len = 16'd3;
        3: len = 16'hFFFF;
        default: len = 16'($urandom_range(1, 2000));
      endcase
      write_reg(pwsg_pkg::REG_PERIOD, len);
      write_reg(pwsg_pkg::REG_VOLUME,
                ph == 1 ? 16'd0 : (ph == 2 ? 16'hFFFF : 16'($urandom)));
      write_reg(pwsg_pkg::REG_WAVE, 16'($urandom_range(3)));
      idle_free = (ph == 5);
      random_phase(70, len);
      drain();
    end
    idle_free = 1'b0;
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
